### rtl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared widths, constants and helpers for the 2D ray / box slab intersector.
// ----------------------------------------------------------------------------
package rbsi_pkg;

	localparam int FRAC_BITS = 16;
	localparam int W         = 32;                // input field width
	localparam int NUM_W     = W + 1;             // bound - origin, signed
	localparam int DEN_W     = W;                 // |dir| magnitude
	localparam int N_W       = NUM_W + FRAC_BITS; // dividend / quotient bits
	localparam int T_W       = N_W + 1;           // signed slab parameter
	localparam int DIV_LAT   = N_W + 2;           // prep + one bit/stage + fixup
	localparam int LAST      = 2 + DIV_LAT + 3;   // output stage index
	localparam int IN_W      = 10 * W;
	localparam int DIST_W    = 31;
	localparam int OUT_W     = 32;
	localparam int PROD_W    = 2 * W;

	localparam logic [W-1:0] TOL_RESET = 32'd429497;

	typedef struct packed {
		logic px;    // x axis counts as parallel
		logic py;    // y axis counts as parallel
		logic inx;   // origin within x bounds
		logic iny;   // origin within y bounds
		logic dznz;  // z direction nonzero
	} side_t;

	function automatic logic [W-1:0] mag32(input logic signed [W-1:0] v);
		mag32 = v[W-1] ? (~v + 1'b1) : v;
	endfunction

	function automatic logic [NUM_W-1:0] mag33(input logic signed [NUM_W-1:0] v);
		mag33 = v[NUM_W-1] ? (~v + 1'b1) : v;
	endfunction

endpackage

### rtl/rbsi_div.sv
// ----------------------------------------------------------------------------
// rbsi_div
// Pipelined restoring divider: floor(num * 2^FRAC_BITS / den), one quotient
// bit per stage, shared stall enable.
// ----------------------------------------------------------------------------
module rbsi_div (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [rbsi_pkg::NUM_W-1:0] num,
	input  logic signed [rbsi_pkg::DEN_W-1:0] den,
	output logic signed [rbsi_pkg::T_W-1:0]   quo
);
	import rbsi_pkg::*;

	logic [N_W-1:0]   dvd_q [0:N_W];  // dividend bits out, quotient bits in
	logic [DEN_W-1:0] rem_q [0:N_W];
	logic [DEN_W-1:0] dsr_q [0:N_W];
	logic             neg_q [0:N_W];
	logic [T_W-1:0]   quo_q;

	// prep stage
	always_ff @(posedge clk) begin
		if (en) begin
			dvd_q[0] <= {mag33(num), {FRAC_BITS{1'b0}}};
			dsr_q[0] <= mag32(den);
			rem_q[0] <= '0;
			neg_q[0] <= num[NUM_W-1] ^ den[DEN_W-1];
		end
	end

	for (genvar k = 1; k <= N_W; k++) begin : g_bit
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;
		assign trial = {rem_q[k-1], dvd_q[k-1][N_W-1]};
		assign diff  = trial - {1'b0, dsr_q[k-1]};
		assign ge    = trial >= {1'b0, dsr_q[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				dvd_q[k] <= {dvd_q[k-1][N_W-2:0], ge};
				dsr_q[k] <= dsr_q[k-1];
				neg_q[k] <= neg_q[k-1];
			end
		end
	end

	// sign fixup, rounding toward minus infinity
	logic [T_W-1:0] qx;
	assign qx = {1'b0, dvd_q[N_W]} + T_W'(|rem_q[N_W]);

	always_ff @(posedge clk) begin
		if (en) begin
			quo_q <= neg_q[N_W] ? (~qx + 1'b1) : {1'b0, dvd_q[N_W]};
		end
	end

	assign quo = $signed(quo_q);

endmodule

### rtl/ray_box_slab_intersect_2d.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_2d
// Clips a 3D ray against the X and Y slabs of a 2D box, Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  s_*     | in  | s_tvalid / s_tready | s_tdata: box + ray, 10 x 32 bits
//  m_*     | out | m_tvalid / m_tready | m_tdata: hit_distance, m_tuser: hit
//  cfg_*   | in  | cfg_valid/cfg_ready | cfg_data: parallel_tolerance
//
//  One transaction per cycle sustained while results are taken; 56 register
//  stages, s1 to s56, with the result held in the s56 output register.
//  Most of the depth is in the five pipelined dividers, 51 stages each
//  (operand prep, one stage per quotient bit for 49 bits, sign fixup).
//  The whole pipeline stalls together when the output register holds a
//  transaction that is not taken; s_tready = !m_tvalid || m_tready.
//  arst_n clears valid bits and reloads the tolerance (about 1e-4).
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_2d (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// box_min_x, box_min_y, box_max_x, box_max_y, ray_origin_x,
	// ray_origin_y, ray_origin_z, ray_dir_x, ray_dir_y, ray_dir_z
	input  logic [rbsi_pkg::IN_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// hit_distance[30:0], zero pad [31]
	output logic [rbsi_pkg::OUT_W-1:0] m_tdata,
	// hit
	output logic                      m_tuser,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [rbsi_pkg::W-1:0]    cfg_data
);
	import rbsi_pkg::*;

	// ---------------- control ----------------
	logic           en;
	logic [LAST:1]  vld_q;
	logic [W-1:0]   tol_q;

	assign en        = !vld_q[LAST] || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			tol_q <= TOL_RESET;
		end else begin
			if (en) vld_q <= {vld_q[LAST-1:1], s_tvalid};
			if (cfg_valid) tol_q <= cfg_data;
		end
	end

	// ---------------- s1: capture ----------------
	logic signed [W-1:0] minx_s1, miny_s1, maxx_s1, maxy_s1;
	logic signed [W-1:0] ox_s1, oy_s1, oz_s1, dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			minx_s1 <= s_tdata[0*W +: W];
			miny_s1 <= s_tdata[1*W +: W];
			maxx_s1 <= s_tdata[2*W +: W];
			maxy_s1 <= s_tdata[3*W +: W];
			ox_s1   <= s_tdata[4*W +: W];
			oy_s1   <= s_tdata[5*W +: W];
			oz_s1   <= s_tdata[6*W +: W];
			dx_s1   <= s_tdata[7*W +: W];
			dy_s1   <= s_tdata[8*W +: W];
			dz_s1   <= s_tdata[9*W +: W];
		end
	end

	// ---------------- s2: slab offsets, magnitudes, bound tests ----------------
	logic signed [NUM_W-1:0] nlox_s2, nhix_s2, nloy_s2, nhiy_s2, nz_s2;
	logic signed [W-1:0]     dx_s2, dy_s2, dz_s2;
	logic [W-1:0]            mdx_s2, mdy_s2, mdz_s2;
	logic                    inx_s2, iny_s2, dznz_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			nlox_s2 <= {minx_s1[W-1], minx_s1} - {ox_s1[W-1], ox_s1};
			nhix_s2 <= {maxx_s1[W-1], maxx_s1} - {ox_s1[W-1], ox_s1};
			nloy_s2 <= {miny_s1[W-1], miny_s1} - {oy_s1[W-1], oy_s1};
			nhiy_s2 <= {maxy_s1[W-1], maxy_s1} - {oy_s1[W-1], oy_s1};
			nz_s2   <= -{oz_s1[W-1], oz_s1};
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			dz_s2   <= dz_s1;
			mdx_s2  <= mag32(dx_s1);
			mdy_s2  <= mag32(dy_s1);
			mdz_s2  <= mag32(dz_s1);
			inx_s2  <= (ox_s1 >= minx_s1) && (ox_s1 <= maxx_s1);
			iny_s2  <= (oy_s1 >= miny_s1) && (oy_s1 <= maxy_s1);
			dznz_s2 <= dz_s1 != '0;
		end
	end

	// ---------------- s3: |dz| * tolerance ----------------
	logic [PROD_W-1:0] rhs_s3;
	logic [W-1:0]      mdx_s3, mdy_s3;
	logic              inx_s3, iny_s3, dznz_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			rhs_s3  <= PROD_W'(mdz_s2) * PROD_W'(tol_q);
			mdx_s3  <= mdx_s2;
			mdy_s3  <= mdy_s2;
			inx_s3  <= inx_s2;
			iny_s3  <= iny_s2;
			dznz_s3 <= dznz_s2;
		end
	end

	// ---------------- s4..s53: parallel flags ride beside the dividers ----------------
	side_t side_new;
	side_t side_dly_q [0:N_W];  // entry 0 is stage 4, entry N_W is stage 53

	always_comb begin
		side_new.px   = {mdx_s3, {W{1'b0}}} <= rhs_s3;
		side_new.py   = {mdy_s3, {W{1'b0}}} <= rhs_s3;
		side_new.inx  = inx_s3;
		side_new.iny  = iny_s3;
		side_new.dznz = dznz_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_dly_q[0] <= side_new;
			for (int k = 1; k <= N_W; k++) side_dly_q[k] <= side_dly_q[k-1];
		end
	end

	// five divides, launched from s2, results at s53
	logic signed [T_W-1:0] t1x, t2x, t1y, t2y, tz;

	rbsi_div u_div_lox (.clk(clk), .en(en), .num(nlox_s2), .den(dx_s2), .quo(t1x));
	rbsi_div u_div_hix (.clk(clk), .en(en), .num(nhix_s2), .den(dx_s2), .quo(t2x));
	rbsi_div u_div_loy (.clk(clk), .en(en), .num(nloy_s2), .den(dy_s2), .quo(t1y));
	rbsi_div u_div_hiy (.clk(clk), .en(en), .num(nhiy_s2), .den(dy_s2), .quo(t2y));
	rbsi_div u_div_z   (.clk(clk), .en(en), .num(nz_s2),   .den(dz_s2), .quo(tz));

	// ---------------- s54: order each slab's pair ----------------
	logic signed [T_W-1:0] lox_s54, hix_s54, loy_s54, hiy_s54, tz_s54;
	side_t                 side_s54;

	always_ff @(posedge clk) begin
		if (en) begin
			lox_s54  <= (t1x > t2x) ? t2x : t1x;
			hix_s54  <= (t1x > t2x) ? t1x : t2x;
			loy_s54  <= (t1y > t2y) ? t2y : t1y;
			hiy_s54  <= (t1y > t2y) ? t1y : t2y;
			tz_s54   <= tz;
			side_s54 <= side_dly_q[N_W];
		end
	end

	// ---------------- s55: combine slabs (parallel axes drop out) ----------------
	logic signed [T_W-1:0] tmin_s55, tmax_s55, tz_s55;
	logic                  both_par_s55, ok_par_s55, dznz_s55;

	always_ff @(posedge clk) begin
		if (en) begin
			if (side_s54.px) begin
				tmin_s55 <= loy_s54;
				tmax_s55 <= hiy_s54;
			end else if (side_s54.py) begin
				tmin_s55 <= lox_s54;
				tmax_s55 <= hix_s54;
			end else begin
				tmin_s55 <= (lox_s54 > loy_s54) ? lox_s54 : loy_s54;
				tmax_s55 <= (hix_s54 < hiy_s54) ? hix_s54 : hiy_s54;
			end
			tz_s55       <= tz_s54;
			both_par_s55 <= side_s54.px && side_s54.py;
			ok_par_s55   <= (!side_s54.px || side_s54.inx) && (!side_s54.py || side_s54.iny);
			dznz_s55     <= side_s54.dznz;
		end
	end

	// ---------------- s56: decide, saturate, output register ----------------
	logic signed [T_W-1:0] tsel;
	logic                  hit_c;
	logic [DIST_W-1:0]     dist_c;
	logic                  hit_s56;
	logic [DIST_W-1:0]     dist_s56;

	always_comb begin
		if (both_par_s55) begin
			tsel  = tz_s55;
			hit_c = ok_par_s55 && dznz_s55 && !tz_s55[T_W-1];
		end else begin
			tsel  = tmin_s55[T_W-1] ? tmax_s55 : tmin_s55;
			hit_c = ok_par_s55 && (tmin_s55 <= tmax_s55) && !tmax_s55[T_W-1];
		end
		if (!hit_c)                         dist_c = '0;
		else if (tsel[T_W-1:DIST_W] != '0)  dist_c = '1;
		else                                dist_c = tsel[DIST_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s56  <= hit_c;
			dist_s56 <= dist_c;
		end
	end

	assign m_tvalid = vld_q[LAST];
	assign m_tuser  = hit_s56;
	assign m_tdata  = {{(OUT_W-DIST_W){1'b0}}, dist_s56};

	// ---------------- assertions ----------------
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_q[1])
		else $error("accepted transaction not in first stage");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("miss with nonzero distance");

endmodule

### tb/ray_box_slab_intersect_2d_test.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_2d_test
// Drives box/ray transactions with random idling on both sides, predicts
// hit flag and distance per transaction, and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ray_box_slab_intersect_2d_test;
	import rbsi_pkg::*;

	localparam int   TOTAL    = 1650;
	localparam int   LATENCY  = 56;
	localparam longint LIMIT  = 400000;
	localparam logic [W-1:0] MAXV = 32'h7FFFFFFF;
	localparam logic [W-1:0] MINV = 32'h80000000;

	typedef struct packed {
		logic [W-1:0] dz, dy, dx, oz, oy, ox, maxy, maxx, miny, minx;
	} ray_box_t;

	typedef struct {
		logic         hit;
		logic [30:0]  span;
	} contact_t;

	// Exact slab intersection on 64-bit signed arithmetic, 128-bit flatness test.
	class contact_scoreboard;
		contact_t     pending[$];
		logic [31:0]  tol;
		int           errors;

		function automatic longint signed floor_div(longint signed num,
				longint signed den);
			longint signed n, q;
			n = num <<< FRAC_BITS;
			q = n / den;
			if ((n % den != 0) && ((n < 0) != (den < 0)))
				q = q - 1;
			return q;
		endfunction

		function automatic logic is_flat(longint signed d, longint signed dz);
			logic [127:0] lhs, rhs;
			lhs = 128'(d < 0 ? -d : d) << 32;
			rhs = 128'(dz < 0 ? -dz : dz) * 128'(tol);
			return lhs <= rhs;
		endfunction

		function automatic logic clip(logic flat, longint signed lo,
				longint signed hi, longint signed o, longint signed d,
				ref longint signed tn, ref longint signed tf);
			longint signed t1, t2, s;
			if (flat)
				return !(o < lo || o > hi);
			t1 = floor_div(lo - o, d);
			t2 = floor_div(hi - o, d);
			if (t1 > t2) begin
				s = t1; t1 = t2; t2 = s;
			end
			if (t1 > tn) tn = t1;
			if (t2 < tf) tf = t2;
			return tn <= tf;
		endfunction

		function void note(ray_box_t r);
			longint signed tn, tf, t, dx, dy, dz;
			logic px, py;
			contact_t c;
			tn = 64'sh8000000000000000;
			tf = 64'sh7FFFFFFFFFFFFFFF;
			dx = longint'(signed'(r.dx));
			dy = longint'(signed'(r.dy));
			dz = longint'(signed'(r.dz));
			px = is_flat(dx, dz);
			py = is_flat(dy, dz);
			c.hit = 0;
			t = 0;
			if (clip(px, signed'(r.minx), signed'(r.maxx), signed'(r.ox), dx, tn, tf)
					&& clip(py, signed'(r.miny), signed'(r.maxy), signed'(r.oy),
					dy, tn, tf) && tf >= 0) begin
				if (px && py) begin
					if (dz != 0) begin
						t = floor_div(-longint'(signed'(r.oz)), dz);
						if (t >= 0) c.hit = 1;
						else t = 0;
					end
				end else begin
					t = (tn >= 0) ? tn : tf;
					c.hit = 1;
				end
			end
			if (!c.hit) t = 0;
			c.span = (t > longint'(MAXV)) ? 31'h7FFFFFFF : t[30:0];
			pending.push_back(c);
		endfunction

		function void check(logic [OUT_W-1:0] data, logic hit);
			contact_t c;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result hit=%0b data=%h", $realtime, hit, data);
				errors++;
				return;
			end
			c = pending.pop_front();
			if (hit !== c.hit) begin
				$display("%0t: hit expected %0b actual %0b", $realtime, c.hit, hit);
				errors++;
			end
			if (data !== {1'b0, c.span}) begin
				$display("%0t: hit_distance expected %h actual %h", $realtime,
					{1'b0, c.span}, data);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               s_tvalid = 0;
	logic               s_tready;
	logic [IN_W-1:0]    s_tdata = '0;
	logic               m_tvalid;
	logic               m_tready = 0;
	logic [OUT_W-1:0]   m_tdata;
	logic               m_tuser;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [W-1:0]       cfg_data = '0;

	contact_scoreboard  board;
	longint             cycles = 0;
	int                 sent = 0;
	bit                 calm = 0;     // no idling near the end of the run

	ray_box_slab_intersect_2d dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Result side: sample at the rising edge, vary tready in bursts.
	initial begin
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				board.check(m_tdata, m_tuser);
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 19);
			end
			m_tready <= (hold == 0);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Register writes happen only while the pipeline is empty.
	task automatic write_tol(logic [W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		board.tol = v;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Send one transaction, with an occasional idle burst before it.
	task automatic send(ray_box_t r);
		if (!calm && $urandom_range(0, 11) == 0) begin
			@(negedge clk);
			s_tvalid <= 0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end else begin
			@(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata  <= r;
		do @(posedge clk); while (!s_tready);
		board.note(r);
		sent++;
	endtask

	function automatic logic [W-1:0] rnd_word();
		case ($urandom_range(0, 7))
			0: return MAXV;
			1: return MINV;
			2: return 32'($signed($urandom_range(0, 2000)) - 1000);
			3: return $urandom;
			default: return 32'($signed($urandom_range(0, 40)) - 20) <<< FRAC_BITS;
		endcase
	endfunction

	// Mostly sane boxes with rays built from edge-case words, plus raw noise.
	function automatic ray_box_t rnd_item();
		ray_box_t r;
		logic signed [W-1:0] a, b;
		r = {$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom, $urandom};
		if ($urandom_range(0, 4) == 0) return r;
		a = rnd_word(); b = rnd_word();
		r.minx = (a < b) ? a : b; r.maxx = (a < b) ? b : a;
		a = rnd_word(); b = rnd_word();
		r.miny = (a < b) ? a : b; r.maxy = (a < b) ? b : a;
		if ($urandom_range(0, 9) == 0) begin
			r.minx = r.maxx; r.maxx = a;   // inverted or degenerate
		end
		r.ox = rnd_word(); r.oy = rnd_word(); r.oz = rnd_word();
		r.dx = rnd_word(); r.dy = rnd_word(); r.dz = rnd_word();
		case ($urandom_range(0, 5))
			0: begin r.dx = 0; r.dy = 0; end
			1: r.dx = $urandom_range(0, 3);
			2: r.dz = 0;
			default: ;
		endcase
		return r;
	endfunction

	function automatic ray_box_t mk(int mnx, int mny, int mxx, int mxy, int ox,
			int oy, int oz, int dx, int dy, int dz);
		ray_box_t r;
		r.minx = mnx; r.miny = mny; r.maxx = mxx; r.maxy = mxy;
		r.ox = ox; r.oy = oy; r.oz = oz; r.dx = dx; r.dy = dy; r.dz = dz;
		return r;
	endfunction

	initial begin
		localparam int ONE = 1 << FRAC_BITS;
		logic [W-1:0] tols[6];
		int per;
		board = new();
		board.tol = TOL_RESET;
		board.errors = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// Directed: hits, misses, parallel axes, z-plane, inverted box, extremes.
		send(mk(0, 0, ONE, ONE, -ONE, ONE/2, 0, ONE, 0, 0));
		send(mk(0, 0, ONE, ONE, ONE/2, ONE/2, 0, ONE, ONE, 0));
		send(mk(0, 0, ONE, ONE, 2*ONE, ONE/2, 0, ONE, 0, 0));
		send(mk(0, 0, ONE, ONE, ONE/2, ONE/2, ONE, 0, 0, -ONE));
		send(mk(0, 0, ONE, ONE, ONE/2, ONE/2, ONE, 0, 0, ONE));
		send(mk(0, 0, ONE, ONE, ONE/2, ONE/2, ONE, 0, 0, 0));
		send(mk(0, 0, ONE, ONE, 2*ONE, ONE/2, ONE, 0, 0, -ONE));
		send(mk(ONE, ONE, 0, 0, ONE/2, ONE/2, ONE, 0, 0, -ONE));
		send(mk(ONE, ONE, 0, 0, -ONE, ONE/2, 0, ONE, 0, 0));
		send(mk(MINV, MINV, MAXV, MAXV, MINV, 0, 0, 1, 0, 0));
		send(mk(MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV));
		send(mk(MAXV, MAXV, MAXV, MAXV, MINV, MINV, MAXV, 1, 1, MINV));
		send(mk(0, 0, ONE, ONE, ONE/2, ONE/2, MAXV, 1, 0, MINV));
		send(mk(0, 0, ONE, ONE, ONE/2, ONE/2, MINV, 0, 0, 1));
		send(mk(0, 0, ONE, ONE, 3*ONE, 3*ONE, 0, -ONE, -ONE, 0));
		send(mk(-ONE, -ONE, ONE, ONE, 0, 0, 0, -1, 1, 0));
		@(negedge clk);
		s_tvalid <= 0;
		drain();

		// Random phases across tolerance settings, extremes included.
		tols = '{32'hFFFFFFFF, 32'h0, 32'h80000000, $urandom, 32'h00010000, TOL_RESET};
		per = (TOTAL - sent) / 6;
		foreach (tols[k]) begin
			write_tol(tols[k]);
			if (k == 5) calm = 0;
			for (int i = 0; i < per; i++) begin
				if (k == 5 && i > per - 120) calm = 1;
				send(rnd_item());
				if (k == 2 && i == per / 2) begin
					// sender holds off until the pipeline empties
					@(negedge clk);
					s_tvalid <= 0;
					while (board.pending.size() != 0) @(posedge clk);
				end
			end
			@(negedge clk);
			s_tvalid <= 0;
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
